// ===== src/esrsc_pkg.sv =====
// Shared types and constants for the remote emergency-stop safety controller.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package esrsc_pkg;

   // Burst geometry
   localparam logic [2:0] HOP_CHANNELS    = 3'd4;
   localparam logic [1:0] GO_BURST_LENGTH = 2'd2;

   // Configuration register reset values
   localparam logic [15:0] DEBOUNCE_MS_RST      = 16'd25;
   localparam logic [15:0] STARTUP_GRACE_MS_RST = 16'd500;
   localparam logic [15:0] STOP_REPEAT_MS_RST   = 16'd30;
   localparam logic [15:0] GO_REPEAT_MS_RST     = 16'd60;
   localparam logic [15:0] HEARTBEAT_MS_RST     = 16'd200;
   localparam logic [15:0] BATT_CRIT_MV_RST     = 16'd10500;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_DEBOUNCE_MS      = 3'd0,
      REG_STARTUP_GRACE_MS = 3'd1,
      REG_STOP_REPEAT_MS   = 3'd2,
      REG_GO_REPEAT_MS     = 3'd3,
      REG_HEARTBEAT_MS     = 3'd4,
      REG_BATT_CRIT_MV     = 3'd5
   } csr_index_type;

   // Safety mode
   typedef enum logic [1:0] {
      MODE_STARTUP = 2'd0,
      MODE_READY   = 2'd1,
      MODE_LATCHED = 2'd2
   } mode_type;

   // Command kind
   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_STOP = 2'd1,
      CMD_GO   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] startup_grace_ms;
      logic [15:0] stop_repeat_ms;
      logic [15:0] go_repeat_ms;
      logic [15:0] heartbeat_period_ms;
      logic [15:0] battery_critical_mv;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        go_raw;
      logic        stop_raw;
      logic [15:0] supply_mv;
      logic        battery_valid;
      logic        link_ok;
      logic [1:0]  hop_channel;
   } req_type;

   typedef struct packed {
      logic [1:0]  cmd_kind;
      logic        cmd_retransmit;
      logic [1:0]  cmd_channel;
      logic        heartbeat_due;
      logic        heartbeat_is_hello;
      logic [1:0]  safety_mode;
      logic        go_debounced;
      logic [31:0] command_count;
   } rsp_type;

   // Controller state carried from tick to tick
   typedef struct packed {
      logic        started;
      logic [31:0] start_time;
      logic [31:0] go_change_time;
      logic        go_stable;
      logic        go_previous;
      logic        startup_checked;
      mode_type    mode;
      logic [31:0] command_count;
      logic [2:0]  stop_burst_left;
      logic [1:0]  go_burst_left;
      logic [31:0] next_burst_time;
      logic [31:0] last_heartbeat_time;
   } state_type;

endpackage
`default_nettype wire

// ===== src/estop_remote_safety_controller_core.sv =====
// Usage
//   Remote emergency-stop safety controller. Each transaction on the req_
//   channel is one tick of the remote unit (time, raw GO/STOP, battery, link,
//   hop channel); each tick yields exactly one rsp_ transaction carrying the
//   command sent, heartbeat flags, safety mode, debounced GO and command count.
//   Transactions are taken when valid is high and stall is low.
//   A tick passes through the input register and then the result register
//   on its way from req to rsp.
//   Throughput: one tick per cycle while rsp_stall is low; the whole tick is
//   evaluated combinationally between the input register and the result
//   register, and the state registers update as the result is captured.
//   When rsp_stall is high the result register holds; the input register still
//   takes one more tick, after which req_stall rises until the result leaves.
//   Reset (synchronous, active high) empties both registers, returns the
//   controller to startup stop with all timers and counters cleared, and
//   loads the configuration registers with their defaults.
//   The csr_ channel is always ready; write it only while no tick is in flight.
// Depends on esrsc_pkg, esrsc_csr and esrsc_tick.
`default_nettype none
module estop_remote_safety_controller_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire esrsc_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output esrsc_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   esrsc_pkg::cfg_type   cfg;
   esrsc_pkg::state_type state_ff;
   esrsc_pkg::state_type state_in;
   esrsc_pkg::req_type   req_ff;
   esrsc_pkg::rsp_type   rsp_ff;
   esrsc_pkg::rsp_type   rsp_in;
   logic                 in_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 load_in;

   esrsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esrsc_tick u_tick (
      .cfg     (cfg),
      .req     (req_ff),
      .st      (state_ff),
      .st_next (state_in),
      .rsp     (rsp_in)
   );

   // Move a tick into the result register when it is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load_in   = !in_valid_ff || advance;
   assign req_stall = !load_in;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
         state_ff.started             <= 1'b0;
         state_ff.start_time          <= 32'd0;
         state_ff.go_change_time      <= 32'd0;
         state_ff.go_stable           <= 1'b0;
         state_ff.go_previous         <= 1'b0;
         state_ff.startup_checked     <= 1'b0;
         state_ff.mode                <= esrsc_pkg::MODE_STARTUP;
         state_ff.command_count       <= 32'd0;
         state_ff.stop_burst_left     <= 3'd0;
         state_ff.go_burst_left       <= 2'd0;
         state_ff.next_burst_time     <= 32'd0;
         state_ff.last_heartbeat_time <= 32'd0;
      end else begin
         if (load_in) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_in && req_valid) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // A latched stop never releases
   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == esrsc_pkg::MODE_LATCHED |=> state_ff.mode == esrsc_pkg::MODE_LATCHED)
      else $error("latched stop was released");

   // No GO burst survives a latched stop
   a_no_go_when_latched: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == esrsc_pkg::MODE_LATCHED |-> state_ff.go_burst_left == 2'd0)
      else $error("GO burst pending while stop latched");

   // STOP burst never exceeds one command per hop channel
   a_stop_burst_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.stop_burst_left <= esrsc_pkg::HOP_CHANNELS)
      else $error("STOP burst count out of range");

   // A STOP command is only reported with the stop latched
   a_stop_cmd_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cmd_kind == esrsc_pkg::CMD_STOP |->
         rsp_ff.safety_mode == esrsc_pkg::MODE_LATCHED)
      else $error("STOP command outside latched mode");

   // Full pipeline with a stalled result must back-pressure the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted while pipeline full");

endmodule
`default_nettype wire

// ===== src/esrsc_csr.sv =====
// Configuration register file for the safety controller.
// Depends on esrsc_pkg for the register indexes and reset values.
`default_nettype none
module esrsc_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [2:0]              csr_index,
   input  wire logic [15:0]             csr_wdata,
   output esrsc_pkg::cfg_type           cfg
);

   esrsc_pkg::cfg_type cfg_ff;
   esrsc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; ignore indexes past the last register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (esrsc_pkg::csr_index_type'(csr_index))
            esrsc_pkg::REG_DEBOUNCE_MS:      cfg_in.debounce_ms         = csr_wdata;
            esrsc_pkg::REG_STARTUP_GRACE_MS: cfg_in.startup_grace_ms    = csr_wdata;
            esrsc_pkg::REG_STOP_REPEAT_MS:   cfg_in.stop_repeat_ms      = csr_wdata;
            esrsc_pkg::REG_GO_REPEAT_MS:     cfg_in.go_repeat_ms        = csr_wdata;
            esrsc_pkg::REG_HEARTBEAT_MS:     cfg_in.heartbeat_period_ms = csr_wdata;
            esrsc_pkg::REG_BATT_CRIT_MV:     cfg_in.battery_critical_mv = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms         <= esrsc_pkg::DEBOUNCE_MS_RST;
         cfg_ff.startup_grace_ms    <= esrsc_pkg::STARTUP_GRACE_MS_RST;
         cfg_ff.stop_repeat_ms      <= esrsc_pkg::STOP_REPEAT_MS_RST;
         cfg_ff.go_repeat_ms        <= esrsc_pkg::GO_REPEAT_MS_RST;
         cfg_ff.heartbeat_period_ms <= esrsc_pkg::HEARTBEAT_MS_RST;
         cfg_ff.battery_critical_mv <= esrsc_pkg::BATT_CRIT_MV_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/esrsc_tick.sv =====
// Combinational evaluation of one tick: next controller state and the result.
// Depends on esrsc_pkg for the state, configuration and payload types.
`default_nettype none
module esrsc_tick (
   input  wire esrsc_pkg::cfg_type   cfg,
   input  wire esrsc_pkg::req_type   req,
   input  wire esrsc_pkg::state_type st,
   output esrsc_pkg::state_type      st_next,
   output esrsc_pkg::rsp_type        rsp
);

   logic                first_tick;
   logic [31:0]         start_t;
   logic [31:0]         go_change_t;
   logic [31:0]         last_hb_t;
   logic [31:0]         go_elapsed;
   logic [31:0]         start_elapsed;
   logic [31:0]         hb_elapsed;
   logic [31:0]         burst_elapsed;
   logic                debounce_passed;
   logic                go_stable_n;
   logic                rising;
   logic                critical;
   logic                stop_hit;
   logic                checked_n;
   esrsc_pkg::mode_type mode_n;
   logic                stop_start;
   logic                go_start;
   logic [2:0]          stop_left_mid;
   logic [1:0]          go_left_mid;
   logic [31:0]         next_burst_mid;
   logic                burst_due;
   logic                send_stop;
   logic                send_go;
   logic                hb_due;
   logic [2:0]          go_chan_wide;

   // Latch the time base on the very first tick
   assign first_tick  = !st.started;
   assign start_t     = first_tick ? req.now_ms : st.start_time;
   assign go_change_t = first_tick ? req.now_ms : st.go_change_time;
   assign last_hb_t   = first_tick ? (req.now_ms - {16'd0, cfg.heartbeat_period_ms})
                                   : st.last_heartbeat_time;

   // Debounce GO and detect its rising edge
   assign go_elapsed      = req.now_ms - go_change_t;
   assign debounce_passed = go_elapsed >= {16'd0, cfg.debounce_ms};
   assign go_stable_n     = (req.go_raw != st.go_stable && debounce_passed) ? req.go_raw
                                                                            : st.go_stable;
   assign rising          = go_stable_n && !st.go_previous;

   // Stop conditions and startup self-check
   assign critical      = !req.battery_valid || (req.supply_mv < cfg.battery_critical_mv);
   assign start_elapsed = req.now_ms - start_t;
   assign stop_hit      = req.stop_raw ||
                          (critical && (st.mode != esrsc_pkg::MODE_STARTUP ||
                                        start_elapsed >= {16'd0, cfg.startup_grace_ms}));
   assign checked_n     = st.startup_checked ||
                          (!stop_hit && start_elapsed >= {16'd0, cfg.debounce_ms});

   // Safety mode next state
   always_comb begin
      unique case (st.mode)
         esrsc_pkg::MODE_STARTUP: begin
            if (stop_hit) begin
               mode_n = esrsc_pkg::MODE_LATCHED;
            end else if (checked_n && req.battery_valid && !critical) begin
               mode_n = esrsc_pkg::MODE_READY;
            end else begin
               mode_n = esrsc_pkg::MODE_STARTUP;
            end
         end
         esrsc_pkg::MODE_READY: begin
            mode_n = stop_hit ? esrsc_pkg::MODE_LATCHED : esrsc_pkg::MODE_READY;
         end
         esrsc_pkg::MODE_LATCHED: mode_n = esrsc_pkg::MODE_LATCHED;
         default:                 mode_n = esrsc_pkg::MODE_LATCHED;
      endcase
   end

   // Start bursts: a new stop latch arms STOP, a ready GO edge with link arms GO
   assign stop_start     = stop_hit && (st.mode != esrsc_pkg::MODE_LATCHED);
   assign go_start       = rising && (mode_n == esrsc_pkg::MODE_READY) && req.link_ok;
   assign stop_left_mid  = stop_start ? esrsc_pkg::HOP_CHANNELS : st.stop_burst_left;
   assign go_left_mid    = stop_hit ? 2'd0 :
                           (go_start ? esrsc_pkg::GO_BURST_LENGTH : st.go_burst_left);
   assign next_burst_mid = (stop_start || go_start) ? req.now_ms : st.next_burst_time;

   // Pick one burst command; STOP wins
   assign burst_elapsed = req.now_ms - next_burst_mid;
   assign burst_due     = !burst_elapsed[31];
   assign send_stop     = (stop_left_mid != 3'd0) && burst_due;
   assign send_go       = !send_stop && (go_left_mid != 2'd0) && burst_due;
   assign go_chan_wide  = {1'b0, req.hop_channel} % esrsc_pkg::HOP_CHANNELS;

   // Heartbeat timer
   assign hb_elapsed = req.now_ms - last_hb_t;
   assign hb_due     = hb_elapsed >= {16'd0, cfg.heartbeat_period_ms};

   // Advance state
   always_comb begin
      st_next.started             = 1'b1;
      st_next.start_time          = start_t;
      st_next.go_change_time      = (req.go_raw == st.go_stable || debounce_passed)
                                    ? req.now_ms : go_change_t;
      st_next.go_stable           = go_stable_n;
      st_next.go_previous         = go_stable_n;
      st_next.startup_checked     = checked_n;
      st_next.mode                = mode_n;
      st_next.command_count       = st.command_count + {31'd0, (stop_start || go_start)};
      st_next.stop_burst_left     = send_stop ? (stop_left_mid - 3'd1) : stop_left_mid;
      st_next.go_burst_left       = send_go ? (go_left_mid - 2'd1) : go_left_mid;
      st_next.next_burst_time     = send_stop ? (req.now_ms + {16'd0, cfg.stop_repeat_ms}) :
                                    send_go   ? (req.now_ms + {16'd0, cfg.go_repeat_ms}) :
                                                next_burst_mid;
      st_next.last_heartbeat_time = hb_due ? req.now_ms : last_hb_t;
   end

   // Build the result transaction
   always_comb begin
      rsp.cmd_kind       = esrsc_pkg::CMD_NONE;
      rsp.cmd_retransmit = 1'b0;
      rsp.cmd_channel    = 2'd0;
      if (send_stop) begin
         rsp.cmd_kind       = esrsc_pkg::CMD_STOP;
         rsp.cmd_retransmit = stop_left_mid != esrsc_pkg::HOP_CHANNELS;
         rsp.cmd_channel    = 2'(esrsc_pkg::HOP_CHANNELS - stop_left_mid);
      end else if (send_go) begin
         rsp.cmd_kind       = esrsc_pkg::CMD_GO;
         rsp.cmd_retransmit = go_left_mid != esrsc_pkg::GO_BURST_LENGTH;
         rsp.cmd_channel    = go_chan_wide[1:0];
      end
      rsp.heartbeat_due      = hb_due;
      rsp.heartbeat_is_hello = hb_due && !req.link_ok;
      rsp.safety_mode        = mode_n;
      rsp.go_debounced       = go_stable_n;
      rsp.command_count      = st_next.command_count;
   end

endmodule
`default_nettype wire

// ===== tb/sv/estop_remote_safety_controller_core_tb.sv =====
// Self-checking testbench for estop_remote_safety_controller_core: a clocked driver
// feeds ticks from a backlog queue, a clocked monitor checks every result against
// an in-bench model of the controller. Depends on esrsc_pkg and the core RTL.
`timescale 1ns / 1ps
module estop_remote_safety_controller_core_tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 4;
   // Indexes past the register file; writes to them must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   esrsc_pkg::req_type   req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   esrsc_pkg::rsp_type   rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [2:0]           csr_index;
   logic [15:0]          csr_wdata;

   // Model copy of the configuration and of the controller state
   esrsc_pkg::cfg_type   cfg;
   esrsc_pkg::state_type st;

   esrsc_pkg::req_type  tick_backlog[$];
   esrsc_pkg::rsp_type  tick_reports_due[$];
   int unsigned ticks_queued   = 0;
   int unsigned ticks_accepted = 0;
   int unsigned failures       = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap       = 0;
   int unsigned hold_left      = 0;
   logic [31:0] now_cursor;
   bit          go_level;
   bit          steady;

   estop_remote_safety_controller_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wrapping elapsed-time test: true once span ms have passed since t_from
   function automatic bit span_elapsed(logic [31:0] t_now, logic [31:0] t_from,
                                       logic [15:0] span);
      return (t_now - t_from) >= 32'(span);
   endfunction

   // Advance the model by one tick and return the report it produces
   function automatic esrsc_pkg::rsp_type advance_controller(esrsc_pkg::req_type t);
      esrsc_pkg::rsp_type r;
      logic        critical;
      logic        rising;
      logic [31:0] lag;
      logic [31:0] slot;
      r = '0;
      critical = !t.battery_valid || (t.supply_mv < cfg.battery_critical_mv);

      // First tick anchors the timers; heartbeat fires at once
      if (!st.started) begin
         st.started             = 1'b1;
         st.start_time          = t.now_ms;
         st.go_change_time      = t.now_ms;
         st.last_heartbeat_time = t.now_ms - 32'(cfg.heartbeat_period_ms);
      end

      // Debounce GO and detect its rising edge
      if (t.go_raw == st.go_stable) begin
         st.go_change_time = t.now_ms;
      end else if (span_elapsed(t.now_ms, st.go_change_time, cfg.debounce_ms)) begin
         st.go_stable      = t.go_raw;
         st.go_change_time = t.now_ms;
      end
      rising         = st.go_stable && !st.go_previous;
      st.go_previous = st.go_stable;

      // Latch stop; a repeat stop only cancels a GO burst
      if (t.stop_raw || (critical && (st.mode != esrsc_pkg::MODE_STARTUP ||
            span_elapsed(t.now_ms, st.start_time, cfg.startup_grace_ms)))) begin
         if (st.mode != esrsc_pkg::MODE_LATCHED) begin
            st.command_count   = st.command_count + 32'd1;
            st.stop_burst_left = esrsc_pkg::HOP_CHANNELS;
            st.next_burst_time = t.now_ms;
         end
         st.mode          = esrsc_pkg::MODE_LATCHED;
         st.go_burst_left = 2'd0;
      end else if (!st.startup_checked &&
                   span_elapsed(t.now_ms, st.start_time, cfg.debounce_ms)) begin
         st.startup_checked = 1'b1;
      end
      if (st.startup_checked && st.mode == esrsc_pkg::MODE_STARTUP && t.battery_valid &&
          !critical) begin
         st.mode = esrsc_pkg::MODE_READY;
      end

      if (rising && st.mode == esrsc_pkg::MODE_READY && t.link_ok) begin
         st.command_count   = st.command_count + 32'd1;
         st.go_burst_left   = esrsc_pkg::GO_BURST_LENGTH;
         st.next_burst_time = t.now_ms;
      end

      // One burst command per tick, STOP first
      lag = t.now_ms - st.next_burst_time;
      if (st.stop_burst_left != 3'd0 && !lag[31]) begin
         r.cmd_kind         = esrsc_pkg::CMD_STOP;
         r.cmd_retransmit   = (st.stop_burst_left != esrsc_pkg::HOP_CHANNELS);
         slot               = (32'(esrsc_pkg::HOP_CHANNELS) - 32'(st.stop_burst_left)) %
                              32'(esrsc_pkg::HOP_CHANNELS);
         r.cmd_channel      = slot[1:0];
         st.stop_burst_left = st.stop_burst_left - 3'd1;
         st.next_burst_time = t.now_ms + 32'(cfg.stop_repeat_ms);
      end else if (st.go_burst_left != 2'd0 && !lag[31]) begin
         r.cmd_kind         = esrsc_pkg::CMD_GO;
         r.cmd_retransmit   = (st.go_burst_left != esrsc_pkg::GO_BURST_LENGTH);
         slot               = 32'(t.hop_channel) % 32'(esrsc_pkg::HOP_CHANNELS);
         r.cmd_channel      = slot[1:0];
         st.go_burst_left   = st.go_burst_left - 2'd1;
         st.next_burst_time = t.now_ms + 32'(cfg.go_repeat_ms);
      end

      if (span_elapsed(t.now_ms, st.last_heartbeat_time, cfg.heartbeat_period_ms)) begin
         st.last_heartbeat_time = t.now_ms;
         r.heartbeat_due        = 1'b1;
         r.heartbeat_is_hello   = !t.link_ok;
      end

      r.safety_mode   = st.mode;
      r.go_debounced  = st.go_stable;
      r.command_count = st.command_count;
      return r;
   endfunction

   task automatic compare_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want_v, got_v);
         failures++;
      end
   endtask

   // Driver: hold a stalled transaction, otherwise idle in bursts or send the next tick
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         st = '0;
      end else begin
         if (req_valid && !req_stall) begin
            tick_reports_due.push_back(advance_controller(req_data));
            ticks_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap == 0 && !steady && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 4);
            end
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_backlog.size() != 0) begin
               req_data  <= tick_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result, stall in random bursts
   always @(posedge clock) begin : watch_results
      esrsc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tick_reports_due.size() == 0) begin
               $display("%0t: result with nothing expected: expected none, actual %0h",
                        $time, rsp_data);
               failures++;
            end else begin
               want = tick_reports_due.pop_front();
               compare_field("cmd_kind", 32'(want.cmd_kind), 32'(rsp_data.cmd_kind));
               compare_field("cmd_retransmit", 32'(want.cmd_retransmit),
                             32'(rsp_data.cmd_retransmit));
               compare_field("cmd_channel", 32'(want.cmd_channel),
                             32'(rsp_data.cmd_channel));
               compare_field("heartbeat_due", 32'(want.heartbeat_due),
                             32'(rsp_data.heartbeat_due));
               compare_field("heartbeat_is_hello", 32'(want.heartbeat_is_hello),
                             32'(rsp_data.heartbeat_is_hello));
               compare_field("safety_mode", 32'(want.safety_mode),
                             32'(rsp_data.safety_mode));
               compare_field("go_debounced", 32'(want.go_debounced),
                             32'(rsp_data.go_debounced));
               compare_field("command_count", want.command_count, rsp_data.command_count);
            end
         end
         if (hold_left == 0 && !steady && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 4);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Track register writes in the model configuration
   always @(posedge clock) begin
      if (reset) begin
         cfg <= '{esrsc_pkg::DEBOUNCE_MS_RST, esrsc_pkg::STARTUP_GRACE_MS_RST,
                  esrsc_pkg::STOP_REPEAT_MS_RST, esrsc_pkg::GO_REPEAT_MS_RST,
                  esrsc_pkg::HEARTBEAT_MS_RST, esrsc_pkg::BATT_CRIT_MV_RST};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            esrsc_pkg::REG_DEBOUNCE_MS:      cfg.debounce_ms         <= csr_wdata;
            esrsc_pkg::REG_STARTUP_GRACE_MS: cfg.startup_grace_ms    <= csr_wdata;
            esrsc_pkg::REG_STOP_REPEAT_MS:   cfg.stop_repeat_ms      <= csr_wdata;
            esrsc_pkg::REG_GO_REPEAT_MS:     cfg.go_repeat_ms        <= csr_wdata;
            esrsc_pkg::REG_HEARTBEAT_MS:     cfg.heartbeat_period_ms <= csr_wdata;
            esrsc_pkg::REG_BATT_CRIT_MV:     cfg.battery_critical_mv <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d results outstanding", $time,
                  tick_reports_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(logic [15:0] deb, logic [15:0] grace, logic [15:0] stop_rep,
                             logic [15:0] go_rep, logic [15:0] hb, logic [15:0] crit);
      csr_write(esrsc_pkg::REG_DEBOUNCE_MS, deb);
      csr_write(esrsc_pkg::REG_STARTUP_GRACE_MS, grace);
      csr_write(esrsc_pkg::REG_STOP_REPEAT_MS, stop_rep);
      csr_write(esrsc_pkg::REG_GO_REPEAT_MS, go_rep);
      csr_write(esrsc_pkg::REG_HEARTBEAT_MS, hb);
      csr_write(esrsc_pkg::REG_BATT_CRIT_MV, crit);
   endtask

   task automatic push_tick(logic [31:0] step, bit go, bit stop_lvl, logic [15:0] batt,
                            bit batt_ok, bit link, logic [1:0] hop);
      esrsc_pkg::req_type t;
      now_cursor      = now_cursor + step;
      t.now_ms        = now_cursor;
      t.go_raw        = go;
      t.stop_raw      = stop_lvl;
      t.supply_mv     = batt;
      t.battery_valid = batt_ok;
      t.link_ok       = link;
      t.hop_channel   = hop;
      tick_backlog.push_back(t);
      ticks_queued++;
   endtask

   // Healthy ticks that keep the controller ready: GO presses with random timing
   task automatic run_ready_ticks(int count, int unsigned max_step, logic [15:0] crit_floor);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 5) == 0) go_level = !go_level;
         push_tick(($urandom_range(0, 15) == 0) ? $urandom_range(0, 70000)
                                                : $urandom_range(0, max_step),
                   go_level, 1'b0, 16'($urandom_range(65535, crit_floor)), 1'b1,
                   $urandom_range(0, 7) != 0, 2'($urandom_range(0, 3)));
      end
   endtask

   // Unconstrained ticks, including time jumps anywhere on the wrapping clock
   task automatic run_noise_ticks(int count);
      for (int i = 0; i < count; i++) begin
         push_tick(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60),
                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 16'($urandom()),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
      end
   endtask

   // Wait until every tick is in and every result is out, then let the pipe settle
   task automatic drain_results();
      while (ticks_accepted != ticks_queued || tick_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      steady     = 1'b0;
      go_level   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Writes past the register file change nothing
      csr_write(REG_SPARE_LO, 16'($urandom()));
      csr_write(REG_SPARE_HI, 16'hFFFF);

      // Startup at reset defaults, crossing the 32-bit time wrap
      now_cursor = 32'hFFFF_FFF0;
      push_tick(0,   1'b0, 1'b0, 16'd0,     1'b1, 1'b0, 2'd0);  // first tick: hello due
      push_tick(15,  1'b0, 1'b0, 16'hFFFF,  1'b0, 1'b1, 2'd3);  // invalid battery in grace
      push_tick(1,   1'b0, 1'b0, 16'd10499, 1'b1, 1'b1, 2'd0);  // critical, time at zero
      push_tick(14,  1'b0, 1'b0, 16'd10500, 1'b1, 1'b1, 2'd1);  // check passes, ready
      push_tick(10,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);
      push_tick(30,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd3);  // GO debounced: burst
      push_tick(30,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);
      push_tick(30,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd1);  // GO repeat
      push_tick(10,  1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd0);
      push_tick(30,  1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd0);
      push_tick(10,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b0, 2'd1);
      push_tick(30,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b0, 2'd1);  // rising edge, link down
      push_tick(10,  1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);
      push_tick(30,  1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);
      push_tick(10,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd0);
      push_tick(30,  1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd0);
      push_tick(0,   1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd0);  // same timestamp twice
      push_tick(110, 1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd3);
      push_tick(1,   1'b0, 1'b0, 16'hFFFF,  1'b1, 1'b1, 2'd3);
      drain_results();

      // Zero timings but for the STOP repeat: instant debounce, back-to-back GO, heartbeat every tick
      set_timing(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      run_ready_ticks(200, 20, 16'd0);
      drain_results();

      // Maximal timings apart from a zero STOP repeat
      set_timing(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_ready_ticks(150, 100, 16'hFFFF);
      drain_results();

      // Mid-range timings
      for (int p = 0; p < 3; p++) begin : mid_phase
         logic [15:0] crit;
         crit = 16'($urandom_range(0, 20000));
         set_timing(16'($urandom_range(1, 40)), 16'($urandom()), 16'($urandom_range(0, 80)),
                    16'($urandom_range(0, 100)), 16'($urandom_range(1, 300)), crit);
         run_ready_ticks(120, 50, crit);
         drain_results();
      end

      // GO burst cut short by a critical battery, then STOP burst and repeat stop
      set_timing(esrsc_pkg::STOP_REPEAT_MS_RST - 16'd5, esrsc_pkg::STARTUP_GRACE_MS_RST,
                 esrsc_pkg::STOP_REPEAT_MS_RST, esrsc_pkg::GO_REPEAT_MS_RST,
                 esrsc_pkg::HEARTBEAT_MS_RST, esrsc_pkg::BATT_CRIT_MV_RST);
      push_tick(30, 1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd1);
      push_tick(30, 1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd1);
      push_tick(30, 1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);  // GO burst starts
      push_tick(30, 1'b1, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd2);
      push_tick(10, 1'b1, 1'b0, 16'd12000, 1'b0, 1'b1, 2'd2);  // invalid battery latches
      push_tick(10, 1'b1, 1'b1, 16'd12000, 1'b1, 1'b1, 2'd2);  // stop while latched
      push_tick(20, 1'b0, 1'b0, 16'd12000, 1'b1, 1'b0, 2'd0);
      push_tick(10, 1'b0, 1'b0, 16'd12000, 1'b1, 1'b0, 2'd0);
      push_tick(0,  1'b0, 1'b0, 16'd12000, 1'b1, 1'b1, 2'd3);
      push_tick(30, 1'b0, 1'b1, 16'd12000, 1'b1, 1'b1, 2'd3);
      push_tick(30, 1'b0, 1'b0, 16'd0,     1'b1, 1'b1, 2'd3);
      push_tick(30, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 2'd3);
      drain_results();

      // Latched: random noise with aggressive timings
      set_timing(16'($urandom_range(0, 30)), 16'($urandom()), 16'd0,
                 16'($urandom()), 16'd1, 16'hFFFF);
      run_noise_ticks(90);
      drain_results();

      // Final stretch with neither side idling
      set_timing(16'($urandom_range(0, 60)), 16'($urandom()), 16'($urandom_range(0, 50)),
                 16'($urandom_range(0, 100)), 16'($urandom_range(1, 300)), 16'($urandom()));
      steady = 1'b1;
      run_noise_ticks(90);
      drain_results();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
